// ===== src/swiss_group_probe_hash_map_defines.svh =====
// Assertion macros for the swiss group probe hash map.
// Included by the modules that check their own logic; no other dependencies.
`ifndef SWISS_GROUP_PROBE_HASH_MAP_DEFINES_SVH
`define SWISS_GROUP_PROBE_HASH_MAP_DEFINES_SVH
`ifndef SYNTHESIS
`define SGPH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sgph: implication check failed");
`define SGPH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sgph: next-cycle check failed");
`else
`define SGPH_ASSERT_IMP(lbl, ante, cons)
`define SGPH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/sgph_pkg.sv =====
// Shared types, constants and helper functions of the swiss group probe hash map.
// No dependencies; used by every module of the block.
package sgph_pkg;

    localparam int GROUP_SLOTS = 16;
    localparam int NUM_GROUPS  = 64;
    localparam int SLOTS       = NUM_GROUPS * GROUP_SLOTS;
    localparam int SLOT_W      = 10;
    localparam int GRP_W       = 6;
    localparam int LANE_W      = 4;
    localparam int ROW_W       = GROUP_SLOTS * 8;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 64;
    localparam int HB_W        = 13;
    localparam int CNT_W       = 11;
    localparam int GL_W        = 3;

    localparam logic [7:0] EMPTY_MARK = 8'h80;
    localparam logic [7:0] TOMB_MARK  = 8'hFE;
    localparam logic [3:0] CAP_LOG2_RESET = 4'd10;
    localparam logic [GL_W-1:0] GL_RESET = 3'd6;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_INSERT,
        OP_ERASE,
        OP_CLEAR
    } sgph_op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NOT_FOUND,
        ST_INSERTED,
        ST_FULL
    } sgph_status_t;

    typedef enum logic [1:0] {
        CTX_INSERT,
        CTX_REHASH,
        CTX_AFTER
    } sgph_ctx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KRD,
        S_KCHK,
        S_KKEY,
        S_KCMP,
        S_FRD,
        S_FCHK,
        S_R1RD,
        S_R1WR,
        S_R2RD,
        S_R2CHK,
        S_R2H,
        S_SW1,
        S_SW2,
        S_SW3,
        S_DONE
    } sgph_state_t;

    typedef struct packed {
        logic                   clr;
        logic                   rd_en;
        logic [GRP_W-1:0]       rd_row;
        logic                   wr_en;
        logic [GRP_W-1:0]       wr_row;
        logic [GROUP_SLOTS-1:0] wr_be;
        logic [ROW_W-1:0]       wr_data;
    } ctrl_req_t;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_slot;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic [KEY_W-1:0]  wr_key;
        logic [VAL_W-1:0]  wr_val;
        logic [HB_W-1:0]   wr_hb;
    } slot_req_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic [HB_W-1:0]  hb;
    } slot_rd_t;

    function automatic logic [LANE_W-1:0] lowest16(input logic [GROUP_SLOTS-1:0] v);
        logic [LANE_W-1:0] r;
        r = '0;
        for (int i = GROUP_SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = LANE_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [GL_W-1:0] eff_gl(input logic [3:0] cl);
        logic [GL_W-1:0] r;
        if (cl < 4'd4) begin
            r = '0;
        end else if (cl > 4'd10) begin
            r = GL_RESET;
        end else begin
            r = GL_W'(cl - 4'd4);
        end
        return r;
    endfunction

endpackage

// ===== src/sgph_ctrl_mem.sv =====
// Control byte store: one 16-byte row per group, with a valid bit per row.
// A row that is not valid reads as all empty markers. Depends on sgph_pkg.
module sgph_ctrl_mem (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sgph_pkg::ctrl_req_t            req,
    output logic [sgph_pkg::ROW_W-1:0]     rd_data
);
    import sgph_pkg::*;

    logic [ROW_W-1:0]      ctrl_mem [NUM_GROUPS];
    logic [NUM_GROUPS-1:0] row_valid_reg;
    logic [ROW_W-1:0]      rd_q_reg;
    logic                  rd_v_reg;

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_q_reg <= ctrl_mem[req.rd_row];
        end
        if (req.wr_en) begin
            for (int b = 0; b < GROUP_SLOTS; b++) begin
                if (req.wr_be[b]) begin
                    ctrl_mem[req.wr_row][b*8 +: 8] <= req.wr_data[b*8 +: 8];
                end else if (!row_valid_reg[req.wr_row]) begin
                    ctrl_mem[req.wr_row][b*8 +: 8] <= EMPTY_MARK;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_v_reg      <= 1'b0;
        end else begin
            if (req.clr) begin
                row_valid_reg <= '0;
            end else if (req.wr_en) begin
                row_valid_reg[req.wr_row] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_v_reg <= row_valid_reg[req.rd_row];
            end
        end
    end

    assign rd_data = rd_v_reg ? rd_q_reg : {GROUP_SLOTS{EMPTY_MARK}};

endmodule

// ===== src/sgph_slot_mem.sv =====
// Slot payload store: key, value and low hash bits, one entry per slot.
// One write and one registered read per cycle. Depends on sgph_pkg.
module sgph_slot_mem (
    input  logic                aclk,
    input  sgph_pkg::slot_req_t req,
    output sgph_pkg::slot_rd_t  rd
);
    import sgph_pkg::*;

    logic [KEY_W-1:0] key_mem [SLOTS];
    logic [VAL_W-1:0] val_mem [SLOTS];
    logic [HB_W-1:0]  hb_mem  [SLOTS];
    slot_rd_t         rd_q_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            key_mem[req.wr_slot] <= req.wr_key;
            val_mem[req.wr_slot] <= req.wr_val;
            hb_mem[req.wr_slot]  <= req.wr_hb;
        end
        if (req.rd_en) begin
            rd_q_reg.key <= key_mem[req.rd_slot];
            rd_q_reg.val <= val_mem[req.rd_slot];
            rd_q_reg.hb  <= hb_mem[req.rd_slot];
        end
    end

    assign rd = rd_q_reg;

endmodule

// ===== src/sgph_seq.sv =====
// Operation sequencer: probes groups, compares keys, inserts, erases and rehashes
// in place through the control and slot stores. Depends on sgph_pkg and the defines.
`include "swiss_group_probe_hash_map_defines.svh"
module sgph_seq (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sgph_pkg::sgph_op_t                in_op,
    input  logic [sgph_pkg::KEY_W-1:0]        in_key,
    input  logic [sgph_pkg::HB_W-1:0]         in_hash,
    input  logic [sgph_pkg::VAL_W-1:0]        in_val,
    input  logic [3:0]                        cap_log2,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sgph_pkg::sgph_status_t            out_status,
    output logic [sgph_pkg::VAL_W-1:0]        out_value,
    output logic [sgph_pkg::CNT_W-1:0]        out_count,
    output sgph_pkg::ctrl_req_t               ctrl_req,
    input  logic [sgph_pkg::ROW_W-1:0]        ctrl_rd,
    output sgph_pkg::slot_req_t               slot_req,
    input  sgph_pkg::slot_rd_t                slot_rd
);
    import sgph_pkg::*;

    sgph_state_t        state_reg, state_next;
    sgph_op_t           op_reg, op_next;
    sgph_ctx_t          ctx_reg, ctx_next;
    sgph_status_t       st_reg, st_next, mst_reg, mst_next;
    logic [KEY_W-1:0]   key_reg, key_next, tk_reg, tk_next;
    logic [VAL_W-1:0]   val_reg, val_next, tv_reg, tv_next, vo_reg, vo_next;
    logic [VAL_W-1:0]   mvo_reg, mvo_next;
    logic [HB_W-1:0]    hash_reg, hash_next, tgt_reg, tgt_next, th_reg, th_next;
    logic [GL_W-1:0]    gl_reg, gl_next;
    logic [CNT_W-1:0]   live_reg, live_next, growth_reg, growth_next;
    logic [CNT_W-1:0]   mcnt_reg, mcnt_next;
    logic [GRP_W-1:0]   grp_reg, grp_next;
    logic [GRP_W:0]     step_reg, step_next;
    logic [GROUP_SLOTS-1:0] cand_reg, cand_next;
    logic [LANE_W-1:0]  j_reg, j_next;
    logic               hasemp_reg, hasemp_next, wasemp_reg, wasemp_next;
    logic [SLOT_W-1:0]  ri_reg, ri_next, ni_reg, ni_next;
    logic               mv_reg, mv_next;

    logic [GRP_W-1:0]       mask;
    logic [GRP_W:0]         ngroups;
    logic [CNT_W-1:0]       usable, half;
    logic [SLOT_W-1:0]      last_slot;
    logic [GROUP_SLOTS-1:0] match_v, empty_v, free_v;
    logic [LANE_W-1:0]      fj;
    logic [SLOT_W-1:0]      fs;
    logic                   fempty, last_step;
    logic [7:0]             cur_byte;
    logic [ROW_W-1:0]       conv_row;
    logic [GL_W-1:0]        new_gl;

    always_comb begin
        mask      = GRP_W'((7'd1 << gl_reg) - 7'd1);
        ngroups   = 7'd1 << gl_reg;
        usable    = 11'd14 << gl_reg;
        half      = 11'd7 << gl_reg;
        last_slot = SLOT_W'((11'd16 << gl_reg) - 11'd1);
        for (int j = 0; j < GROUP_SLOTS; j++) begin
            match_v[j]           = ctrl_rd[j*8 +: 8] == {1'b0, tgt_reg[6:0]};
            empty_v[j]           = ctrl_rd[j*8 +: 8] == EMPTY_MARK;
            free_v[j]            = ctrl_rd[j*8 + 7];
            conv_row[j*8 +: 8]   = ctrl_rd[j*8 + 7] ? EMPTY_MARK : TOMB_MARK;
        end
        fj        = lowest16(free_v);
        fs        = {grp_reg, fj};
        fempty    = empty_v[fj];
        last_step = step_reg == ngroups;
        cur_byte  = ctrl_rd[{ri_reg[LANE_W-1:0], 3'b000} +: 8];
        new_gl    = eff_gl(cap_log2);
    end

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        ctx_next    = ctx_reg;
        st_next     = st_reg;
        mst_next    = mst_reg;
        key_next    = key_reg;
        tk_next     = tk_reg;
        val_next    = val_reg;
        tv_next     = tv_reg;
        vo_next     = vo_reg;
        mvo_next    = mvo_reg;
        hash_next   = hash_reg;
        tgt_next    = tgt_reg;
        th_next     = th_reg;
        gl_next     = gl_reg;
        live_next   = live_reg;
        growth_next = growth_reg;
        mcnt_next   = mcnt_reg;
        grp_next    = grp_reg;
        step_next   = step_reg;
        cand_next   = cand_reg;
        j_next      = j_reg;
        hasemp_next = hasemp_reg;
        wasemp_next = wasemp_reg;
        ri_next     = ri_reg;
        ni_next     = ni_reg;
        mv_next     = mv_reg && !m_ready;
        ctrl_req    = '0;
        slot_req    = '0;
        s_ready     = state_reg == S_IDLE;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next   = in_op;
                    key_next  = in_key;
                    hash_next = in_hash;
                    val_next  = in_val;
                    tgt_next  = in_hash;
                    st_next   = ST_OK;
                    vo_next   = '0;
                    grp_next  = in_hash[HB_W-1:7] & mask;
                    step_next = 7'd1;
                    if (in_op == OP_CLEAR) begin
                        gl_next      = new_gl;
                        live_next    = '0;
                        growth_next  = 11'd14 << new_gl;
                        ctrl_req.clr = 1'b1;
                        state_next   = S_DONE;
                    end else begin
                        state_next = S_KRD;
                    end
                end
            end
            S_KRD: begin
                ctrl_req.rd_en  = 1'b1;
                ctrl_req.rd_row = grp_reg;
                state_next      = S_KCHK;
            end
            S_KCHK: begin
                hasemp_next = |empty_v;
                if (|match_v) begin
                    cand_next  = match_v;
                    state_next = S_KKEY;
                end else if ((|empty_v) || last_step) begin
                    if (op_reg == OP_INSERT) begin
                        grp_next   = hash_reg[HB_W-1:7] & mask;
                        step_next  = 7'd1;
                        tgt_next   = hash_reg;
                        ctx_next   = CTX_INSERT;
                        state_next = S_FRD;
                    end else begin
                        st_next    = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                end else begin
                    grp_next   = (grp_reg + step_reg[GRP_W-1:0]) & mask;
                    step_next  = step_reg + 7'd1;
                    state_next = S_KRD;
                end
            end
            S_KKEY: begin
                j_next               = lowest16(cand_reg);
                cand_next            = cand_reg & ~(16'(1) << lowest16(cand_reg));
                slot_req.rd_en       = 1'b1;
                slot_req.rd_slot     = {grp_reg, lowest16(cand_reg)};
                state_next           = S_KCMP;
            end
            S_KCMP: begin
                if (slot_rd.key == key_reg) begin
                    state_next = S_DONE;
                    case (op_reg)
                        OP_LOOKUP: begin
                            vo_next = slot_rd.val;
                        end
                        OP_INSERT: begin
                            slot_req.wr_en   = 1'b1;
                            slot_req.wr_slot = {grp_reg, j_reg};
                            slot_req.wr_key  = key_reg;
                            slot_req.wr_val  = val_reg;
                            slot_req.wr_hb   = slot_rd.hb;
                        end
                        default: begin
                            ctrl_req.wr_en   = 1'b1;
                            ctrl_req.wr_row  = grp_reg;
                            ctrl_req.wr_be   = 16'(1) << j_reg;
                            ctrl_req.wr_data = {GROUP_SLOTS{hasemp_reg ? EMPTY_MARK
                                                                       : TOMB_MARK}};
                            if (hasemp_reg) begin
                                growth_next = growth_reg + 11'd1;
                            end
                            if (live_reg != '0) begin
                                live_next = live_reg - 11'd1;
                            end
                        end
                    endcase
                end else if (cand_reg != '0) begin
                    state_next = S_KKEY;
                end else if (hasemp_reg || last_step) begin
                    if (op_reg == OP_INSERT) begin
                        grp_next   = hash_reg[HB_W-1:7] & mask;
                        step_next  = 7'd1;
                        tgt_next   = hash_reg;
                        ctx_next   = CTX_INSERT;
                        state_next = S_FRD;
                    end else begin
                        st_next    = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                end else begin
                    grp_next   = (grp_reg + step_reg[GRP_W-1:0]) & mask;
                    step_next  = step_reg + 7'd1;
                    state_next = S_KRD;
                end
            end
            S_FRD: begin
                ctrl_req.rd_en  = 1'b1;
                ctrl_req.rd_row = grp_reg;
                state_next      = S_FCHK;
            end
            S_FCHK: begin
                if (!(|free_v) && !last_step) begin
                    grp_next   = (grp_reg + step_reg[GRP_W-1:0]) & mask;
                    step_next  = step_reg + 7'd1;
                    state_next = S_FRD;
                end else if (ctx_reg == CTX_REHASH) begin
                    if (!(|free_v) || fs[SLOT_W-1:LANE_W] == ri_reg[SLOT_W-1:LANE_W]) begin
                        ctrl_req.wr_en   = 1'b1;
                        ctrl_req.wr_row  = ri_reg[SLOT_W-1:LANE_W];
                        ctrl_req.wr_be   = 16'(1) << ri_reg[LANE_W-1:0];
                        ctrl_req.wr_data = {GROUP_SLOTS{1'b0, tgt_reg[6:0]}};
                        if (ri_reg == last_slot) begin
                            growth_next = usable - live_reg;
                            grp_next    = hash_reg[HB_W-1:7] & mask;
                            step_next   = 7'd1;
                            tgt_next    = hash_reg;
                            ctx_next    = CTX_AFTER;
                            state_next  = S_FRD;
                        end else begin
                            ri_next    = ri_reg + 10'd1;
                            state_next = S_R2RD;
                        end
                    end else begin
                        ni_next          = fs;
                        wasemp_next      = fempty;
                        slot_req.rd_en   = 1'b1;
                        slot_req.rd_slot = fs;
                        state_next       = S_SW1;
                    end
                end else if (!(|free_v)) begin
                    st_next    = ST_FULL;
                    state_next = S_DONE;
                end else if (ctx_reg == CTX_INSERT && growth_reg == '0 && fempty) begin
                    if (live_reg >= half) begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end else begin
                        ri_next    = '0;
                        state_next = S_R1RD;
                    end
                end else begin
                    if (fempty && growth_reg != '0) begin
                        growth_next = growth_reg - 11'd1;
                    end
                    ctrl_req.wr_en   = 1'b1;
                    ctrl_req.wr_row  = grp_reg;
                    ctrl_req.wr_be   = 16'(1) << fj;
                    ctrl_req.wr_data = {GROUP_SLOTS{1'b0, hash_reg[6:0]}};
                    slot_req.wr_en   = 1'b1;
                    slot_req.wr_slot = fs;
                    slot_req.wr_key  = key_reg;
                    slot_req.wr_val  = val_reg;
                    slot_req.wr_hb   = hash_reg;
                    live_next        = live_reg + 11'd1;
                    st_next          = ST_INSERTED;
                    state_next       = S_DONE;
                end
            end
            S_R1RD: begin
                ctrl_req.rd_en  = 1'b1;
                ctrl_req.rd_row = ri_reg[GRP_W-1:0];
                state_next      = S_R1WR;
            end
            S_R1WR: begin
                ctrl_req.wr_en   = 1'b1;
                ctrl_req.wr_row  = ri_reg[GRP_W-1:0];
                ctrl_req.wr_be   = '1;
                ctrl_req.wr_data = conv_row;
                if (ri_reg[GRP_W-1:0] == mask) begin
                    ri_next    = '0;
                    state_next = S_R2RD;
                end else begin
                    ri_next    = ri_reg + 10'd1;
                    state_next = S_R1RD;
                end
            end
            S_R2RD: begin
                ctrl_req.rd_en  = 1'b1;
                ctrl_req.rd_row = ri_reg[SLOT_W-1:LANE_W];
                state_next      = S_R2CHK;
            end
            S_R2CHK: begin
                if (cur_byte == TOMB_MARK) begin
                    slot_req.rd_en   = 1'b1;
                    slot_req.rd_slot = ri_reg;
                    state_next       = S_R2H;
                end else if (ri_reg == last_slot) begin
                    growth_next = usable - live_reg;
                    grp_next    = hash_reg[HB_W-1:7] & mask;
                    step_next   = 7'd1;
                    tgt_next    = hash_reg;
                    ctx_next    = CTX_AFTER;
                    state_next  = S_FRD;
                end else begin
                    ri_next    = ri_reg + 10'd1;
                    state_next = S_R2RD;
                end
            end
            S_R2H: begin
                tk_next    = slot_rd.key;
                tv_next    = slot_rd.val;
                th_next    = slot_rd.hb;
                tgt_next   = slot_rd.hb;
                grp_next   = slot_rd.hb[HB_W-1:7] & mask;
                step_next  = 7'd1;
                ctx_next   = CTX_REHASH;
                state_next = S_FRD;
            end
            S_SW1: begin
                slot_req.wr_en   = 1'b1;
                slot_req.wr_slot = ni_reg;
                slot_req.wr_key  = tk_reg;
                slot_req.wr_val  = tv_reg;
                slot_req.wr_hb   = th_reg;
                tk_next          = slot_rd.key;
                tv_next          = slot_rd.val;
                th_next          = slot_rd.hb;
                state_next       = S_SW2;
            end
            S_SW2: begin
                slot_req.wr_en   = 1'b1;
                slot_req.wr_slot = ri_reg;
                slot_req.wr_key  = tk_reg;
                slot_req.wr_val  = tv_reg;
                slot_req.wr_hb   = th_reg;
                ctrl_req.wr_en   = 1'b1;
                ctrl_req.wr_row  = ni_reg[SLOT_W-1:LANE_W];
                ctrl_req.wr_be   = 16'(1) << ni_reg[LANE_W-1:0];
                ctrl_req.wr_data = {GROUP_SLOTS{1'b0, tgt_reg[6:0]}};
                state_next       = S_SW3;
            end
            S_SW3: begin
                if (!wasemp_reg) begin
                    state_next = S_R2RD;
                end else begin
                    ctrl_req.wr_en   = 1'b1;
                    ctrl_req.wr_row  = ri_reg[SLOT_W-1:LANE_W];
                    ctrl_req.wr_be   = 16'(1) << ri_reg[LANE_W-1:0];
                    ctrl_req.wr_data = {GROUP_SLOTS{EMPTY_MARK}};
                    if (ri_reg == last_slot) begin
                        growth_next = usable - live_reg;
                        grp_next    = hash_reg[HB_W-1:7] & mask;
                        step_next   = 7'd1;
                        tgt_next    = hash_reg;
                        ctx_next    = CTX_AFTER;
                        state_next  = S_FRD;
                    end else begin
                        ri_next    = ri_reg + 10'd1;
                        state_next = S_R2RD;
                    end
                end
            end
            S_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mst_next   = st_reg;
                    mvo_next   = vo_reg;
                    mcnt_next  = live_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            gl_reg     <= GL_RESET;
            live_reg   <= '0;
            growth_reg <= 11'd14 << GL_RESET;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            gl_reg     <= gl_next;
            live_reg   <= live_next;
            growth_reg <= growth_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        ctx_reg    <= ctx_next;
        st_reg     <= st_next;
        mst_reg    <= mst_next;
        key_reg    <= key_next;
        tk_reg     <= tk_next;
        val_reg    <= val_next;
        tv_reg     <= tv_next;
        vo_reg     <= vo_next;
        mvo_reg    <= mvo_next;
        hash_reg   <= hash_next;
        tgt_reg    <= tgt_next;
        th_reg     <= th_next;
        mcnt_reg   <= mcnt_next;
        grp_reg    <= grp_next;
        step_reg   <= step_next;
        cand_reg   <= cand_next;
        j_reg      <= j_next;
        hasemp_reg <= hasemp_next;
        wasemp_reg <= wasemp_next;
        ri_reg     <= ri_next;
        ni_reg     <= ni_next;
    end

    assign m_valid    = mv_reg;
    assign out_status = mst_reg;
    assign out_value  = mvo_reg;
    assign out_count  = mcnt_reg;

    `SGPH_ASSERT_IMP(a_budget, (state_reg == S_IDLE), ((12'(live_reg) + 12'(growth_reg)) <= 12'(usable)))
    `SGPH_ASSERT_NXT(a_busy_after_accept, (s_valid && s_ready), (!s_ready))
    `SGPH_ASSERT_IMP(a_idle_no_write, (state_reg == S_IDLE), (!ctrl_req.wr_en && !slot_req.wr_en))

endmodule

// ===== src/swiss_group_probe_hash_map.sv =====
// Swiss-table style hash map with 16-slot groups, triangular probing and in-place rehash.
// Top level: stream channels, register port, sequencer and the two stores.
// Depends on sgph_pkg, sgph_ctrl_mem, sgph_slot_mem and sgph_seq.
//
// Each input beat is one operation (s_tuser: lookup, insert or assign, erase, clear)
// with a key handle, a 64-bit hash and a value; each yields exactly one result beat
// with a status, the found value and the live entry count.
// One operation is in flight at a time; s_tready is low while it runs.
// A group probe reads one row of the control byte store, and every tag
// candidate then reads the slot store for a key compare; a clear resets
// the row valid bits and the entry counts.
// An in-place rehash walks every row of the current capacity, then every slot,
// with a free-slot probe for each full entry and a swap for each moved entry.
// The capacity register is written through the APB port and takes effect at the
// next clear. Reset marks all control rows empty at once and sets a capacity of
// 1024 slots. A result waits in the output register while m_tready is low, and
// the block still accepts the next operation meanwhile.
module swiss_group_probe_hash_map (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // key[31:0], hash[95:32], value[159:96]
    input  logic [1:0]   s_tuser,   // op[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // value_out[63:0], entry_count[74:64], zero pad
    output logic [1:0]   m_tuser,   // status[1:0]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import sgph_pkg::*;

    logic [3:0]         cap_log2_reg;
    ctrl_req_t          ctrl_req;
    logic [ROW_W-1:0]   ctrl_rd;
    slot_req_t          slot_req;
    slot_rd_t           slot_rd;
    sgph_status_t       out_status;
    logic [VAL_W-1:0]   out_value;
    logic [CNT_W-1:0]   out_count;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {28'd0, cap_log2_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_log2_reg <= CAP_LOG2_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            cap_log2_reg <= pwdata[3:0];
        end
    end

    sgph_ctrl_mem u_ctrl_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ctrl_req),
        .rd_data (ctrl_rd)
    );

    sgph_slot_mem u_slot_mem (
        .aclk (aclk),
        .req  (slot_req),
        .rd   (slot_rd)
    );

    sgph_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .in_op      (sgph_op_t'(s_tuser)),
        .in_key     (s_tdata[31:0]),
        .in_hash    (s_tdata[32 +: HB_W]),
        .in_val     (s_tdata[159:96]),
        .cap_log2   (cap_log2_reg),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .out_status (out_status),
        .out_value  (out_value),
        .out_count  (out_count),
        .ctrl_req   (ctrl_req),
        .ctrl_rd    (ctrl_rd),
        .slot_req   (slot_req),
        .slot_rd    (slot_rd)
    );

    assign m_tdata = {5'd0, out_count, out_value};
    assign m_tuser = out_status;

endmodule
